@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ rtl/scbp_pkg.sv @@
package scbp_pkg;

   localparam int NUM_CLASSES = 5;
   localparam int NUM_BUFFERS = 13;

   localparam int BUF_IDX_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CLS_IDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SIZE_W     = 16;
   localparam int HANDLE_W   = 4;
   localparam int CLASS_W    = 3;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CLASS_COUNT [NUM_CLASSES] = '{1, 5, 1, 5, 1};
   localparam logic [SIZE_W-1:0] CLASS_SIZE_RESET [NUM_CLASSES] =
      '{16'd20, 16'd50, 16'd120, 16'd256, 16'd512};

   // register map: class_size_0 sits at the base, the others follow
   localparam logic [CSR_IDX_W-1:0] REG_CLASS_SIZE_BASE = 3'd0;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED    = 3'd0,
      ST_FREED        = 3'd1,
      ST_ALREADY_FREE = 3'd2,
      ST_NO_BUFFER    = 3'd3,
      ST_INVALID      = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic commit;
   } ctl_cmd_type;

   // first buffer index of a class
   function automatic logic [BUF_IDX_W-1:0] class_first(input logic [CLS_IDX_W-1:0] cls);
      int sum;
      sum = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (c < int'(cls)) sum += CLASS_COUNT[c];
      end
      return BUF_IDX_W'(sum);
   endfunction

   // class that holds a buffer index
   function automatic logic [CLASS_W-1:0] class_of(input logic [BUF_IDX_W-1:0] buf_idx);
      int start;
      logic [CLASS_W-1:0] cls;
      logic found;
      start = 0;
      cls = CLASS_W'(NUM_CLASSES - 1);
      found = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         start += CLASS_COUNT[c];
         if (!found && int'(buf_idx) < start) begin
            cls = CLASS_W'(c);
            found = 1'b1;
         end
      end
      return cls;
   endfunction

endpackage

@@ rtl/scbp_req_if.sv @@
interface scbp_req_if import scbp_pkg::*;;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SIZE_W-1:0]   req_size;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output cmd, output req_size, output handle, input ready);
   modport sink   (input valid, input cmd, input req_size, input handle, output ready);
endinterface

@@ rtl/scbp_rsp_if.sv @@
interface scbp_rsp_if import scbp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] granted_handle;
   logic [CLASS_W-1:0]  granted_class;

   modport source (output valid, output status, output granted_handle, output granted_class,
                   input ready);
   modport sink   (input valid, input status, input granted_handle, input granted_class,
                   output ready);
endinterface

@@ rtl/scbp_csr_if.sv @@
interface scbp_csr_if import scbp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/scbp_ctrl.sv @@
`include "assert_macros.svh"

module scbp_ctrl import scbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctl_cmd_type ctl_cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_xfer;
   logic           commit;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   // result register is free or emptied in this cycle
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign ctl_cmd.load_req = req_xfer;
   assign ctl_cmd.commit   = commit;
   assign rsp_valid        = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_CLKD(a_commit_gives_rsp, clock, reset, commit |=> rsp_valid_ff)
   `ASSERT_CLKD(a_accept_starts_exec, clock, reset, req_xfer |=> (state_ff == S_EXEC))
   `ASSERT_CLKD(a_stall_holds_exec, clock, reset,
                ((state_ff == S_EXEC) && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_EXEC))

endmodule

@@ rtl/scbp_dpath.sv @@
`include "assert_macros.svh"

module scbp_dpath import scbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           ctl_cmd,
   input  logic                  req_cmd,
   input  logic [SIZE_W-1:0]     req_size,
   input  logic [HANDLE_W-1:0]   req_handle,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [HANDLE_W-1:0]   rsp_granted_handle,
   output logic [CLASS_W-1:0]    rsp_granted_class
);

   logic [SIZE_W-1:0]      class_size_ff [NUM_CLASSES];
   logic [NUM_BUFFERS-1:0] free_map_ff, free_map_in;

   cmd_type                cmd_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [HANDLE_W-1:0]    handle_ff;

   status_type             status_ff, status_in;
   logic [HANDLE_W-1:0]    gh_ff, gh_in;
   logic [CLASS_W-1:0]     gc_ff, gc_in;

   logic                   cls_found;
   logic [CLS_IDX_W-1:0]   cls_idx;
   logic [BUF_IDX_W-1:0]   first_idx;
   logic                   buf_hit;
   logic [BUF_IDX_W-1:0]   buf_idx;
   logic                   handle_ok;
   logic                   handle_free;

   // first class in index order whose size covers the request
   always_comb begin
      cls_found = 1'b0;
      cls_idx   = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (size_ff <= class_size_ff[c]) begin
            cls_found = 1'b1;
            cls_idx   = CLS_IDX_W'(c);
         end
      end
   end

   assign first_idx = class_first(cls_idx);

   // lowest free buffer at or above the first buffer of that class
   always_comb begin
      buf_hit = 1'b0;
      buf_idx = '0;
      for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
         if (free_map_ff[b] && (b >= int'(first_idx))) begin
            buf_hit = 1'b1;
            buf_idx = BUF_IDX_W'(b);
         end
      end
   end

   assign handle_ok   = (int'(handle_ff) < NUM_BUFFERS);
   assign handle_free = handle_ok ? free_map_ff[BUF_IDX_W'(handle_ff)] : 1'b0;

   always_comb begin
      free_map_in = free_map_ff;
      status_in   = ST_NO_BUFFER;
      gh_in       = '0;
      gc_in       = '0;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            if (cls_found && buf_hit) begin
               status_in            = ST_ALLOCATED;
               gh_in                = HANDLE_W'(buf_idx);
               gc_in                = class_of(buf_idx);
               free_map_in[buf_idx] = 1'b0;
            end
         end
         CMD_FREE: begin
            priority if (!handle_ok) begin
               status_in = ST_INVALID;
            end else if (handle_free) begin
               status_in = ST_ALREADY_FREE;
            end else begin
               status_in = ST_FREED;
               free_map_in[BUF_IDX_W'(handle_ff)] = 1'b1;
            end
         end
         default: status_in = ST_NO_BUFFER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
         for (int c = 0; c < NUM_CLASSES; c++) class_size_ff[c] <= CLASS_SIZE_RESET[c];
      end else begin
         if (ctl_cmd.commit) free_map_ff <= free_map_in;
         // indexes past the last class are dropped
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (csr_we && (csr_index == REG_CLASS_SIZE_BASE + CSR_IDX_W'(c))) begin
               class_size_ff[c] <= SIZE_W'(csr_data);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_req) begin
         cmd_ff    <= cmd_type'(req_cmd);
         size_ff   <= req_size;
         handle_ff <= req_handle;
      end
      if (ctl_cmd.commit) begin
         status_ff <= status_in;
         gh_ff     <= gh_in;
         gc_ff     <= gc_in;
      end
   end

   assign rsp_status         = STATUS_W'(status_ff);
   assign rsp_granted_handle = gh_ff;
   assign rsp_granted_class  = gc_ff;

   `ASSERT_CLKD(a_alloc_takes_one, clock, reset,
                (ctl_cmd.commit && (status_in == ST_ALLOCATED)) |=>
                ($countones(free_map_ff) + 1 == $past($countones(free_map_ff))))
   `ASSERT_CLKD(a_free_returns_one, clock, reset,
                (ctl_cmd.commit && (status_in == ST_FREED)) |=>
                ($countones(free_map_ff) == $past($countones(free_map_ff)) + 1))
   `ASSERT_CLKD(a_reject_keeps_map, clock, reset,
                (ctl_cmd.commit && (status_in == ST_NO_BUFFER || status_in == ST_INVALID ||
                 status_in == ST_ALREADY_FREE)) |=> $stable(free_map_ff))

endmodule

@@ rtl/size_class_buffer_pool_core.sv @@
// a request is loaded into the request registers, then committed to the output register once it is free
// a new request is taken only once the previous one is committed; the class
//    compare, the free-map priority search and the map update share the same commit cycle
// a new request is taken while the previous result waits in the output register
// reset: free map all ones (every buffer free), class sizes 20, 50, 120, 256, 512
module size_class_buffer_pool_core import scbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   scbp_req_if.sink   req_ch,
   scbp_rsp_if.source rsp_ch,
   scbp_csr_if.sink   csr_ch
);

   ctl_cmd_type ctl_cmd;
   logic        csr_we;

   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid && csr_ch.ready;

   scbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl_cmd   (ctl_cmd)
   );

   scbp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl_cmd            (ctl_cmd),
      .req_cmd            (req_ch.cmd),
      .req_size           (req_ch.req_size),
      .req_handle         (req_ch.handle),
      .csr_we             (csr_we),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_status         (rsp_ch.status),
      .rsp_granted_handle (rsp_ch.granted_handle),
      .rsp_granted_class  (rsp_ch.granted_class)
   );

endmodule
